// ----- rtl/core/mlgs_pkg.sv -----
// ----------------------------------------------------------------------------
// mlgs_pkg
// Shared widths, codes and status types of the mesh Life generation block.
// ----------------------------------------------------------------------------
package mlgs_pkg;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 13;
  localparam int VALUE_W  = 14;
  localparam int GENS_W   = 8;
  localparam int COUNT_W  = 11;

  // neighbour count saturates: anything above three behaves the same
  localparam int          LIVE_W       = 3;
  localparam logic [2:0]  LIVE_SAT     = 3'd4;
  localparam logic [2:0]  BIRTH_COUNT  = 3'd3;
  localparam logic [2:0]  SURVIVE_LOW  = 3'd2;
  localparam logic [2:0]  SURVIVE_HIGH = 3'd3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_CELL     = 3'd0,
    OP_WRITE_ROW      = 3'd1,
    OP_WRITE_NEIGHBOR = 3'd2,
    OP_RUN            = 3'd3,
    OP_READ_CELL      = 3'd4
  } opcode_t;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

// ----- rtl/core/mlgs_if.sv -----
// ----------------------------------------------------------------------------
// mlgs_if
// Valid/ready channels of the mesh Life block: items, results, configuration.
// ----------------------------------------------------------------------------
interface mlgs_item_if;
  logic                         valid;
  logic                         ready;
  logic [mlgs_pkg::OPCODE_W-1:0] opcode;
  logic [mlgs_pkg::INDEX_W-1:0]  index;
  logic [mlgs_pkg::VALUE_W-1:0]  value;
  logic [mlgs_pkg::GENS_W-1:0]   generations;

  modport source (output valid, output opcode, output index, output value,
                  output generations, input ready);
  modport sink   (input valid, input opcode, input index, input value,
                  input generations, output ready);
endinterface

interface mlgs_result_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic any_changed;
  logic status;

  modport source (output valid, output cell_alive, output any_changed,
                  output status, input ready);
  modport sink   (input valid, input cell_alive, input any_changed,
                  input status, output ready);
endinterface

interface mlgs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mlgs_pkg::COUNT_W-1:0] cell_count;

  modport source (output valid, output cell_count, input ready);
  modport sink   (input valid, input cell_count, output ready);
endinterface

// ----- rtl/core/mesh_life_generation_step.sv -----
// ----------------------------------------------------------------------------
// mesh_life_generation_step: Life B3/S23 on a mesh held in compressed rows.
// Loads: result valid in the cycle after transfer. Read cell: S_READ, then the
// registered result. Run: per generation S_GEN, then for each of MAX_CELLS cells
// S_CELL, S_HI and, for a cell in use, the neighbour list / cell RAM walk (S_EDGE).
// Reset clears both cell banks in S_CLEAR; no item taken meanwhile.
// ----------------------------------------------------------------------------
module mesh_life_generation_step #(
  parameter int MAX_CELLS = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic          clk,
  input  logic          rst,
  mlgs_item_if.sink     item,
  mlgs_result_if.source result,
  mlgs_cfg_if.sink      cfg
);

  localparam int CW  = $clog2(MAX_CELLS);
  localparam int CNW = $clog2(MAX_CELLS+1);
  localparam int RSW = $clog2(MAX_CELLS+1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int OW  = $clog2(MAX_EDGES+1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_GEN   = 7'b0001000,
    S_CELL  = 7'b0010000,
    S_HI    = 7'b0100000,
    S_EDGE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CW-1:0]                 clr;
  logic                          active_bank;
  logic [mlgs_pkg::COUNT_W-1:0]  cell_count;
  logic                          res_valid;
  logic                          res_alive;
  logic                          res_any;
  logic                          res_status;

  logic [CW-1:0]                 c;
  logic                          gen_changed;
  logic [mlgs_pkg::GENS_W-1:0]   gens_left;
  logic [OW-1:0]                 lo;
  logic [OW-1:0]                 hi_raw;
  logic                          me_r;

  logic                          in_xfer;
  logic [CNW-1:0]                n_lim;
  logic                          in_use;
  logic                          last_cell;
  logic                          me_bit;
  logic                          nx;
  logic                          new_bit;
  logic                          flip;
  logic                          commit;
  logic [OW-1:0]                 hi_clamped;

  logic                          res_load;
  logic                          res_alive_next;
  logic                          res_any_next;
  logic                          res_status_next;

  logic                          a_we;
  logic                          b_we;
  logic [CW-1:0]                 c_waddr;
  logic                          c_wdata;
  logic [CW-1:0]                 c_raddr;
  logic                          a_rdata;
  logic                          b_rdata;
  logic                          cur_rdata;

  logic                          rs_we;
  logic [RSW-1:0]                rs_raddr;
  logic [OW-1:0]                 rs_rdata;
  logic                          nl_we;
  logic [EW-1:0]                 nl_raddr;
  logic [CW-1:0]                 nl_rdata;

  logic                          walk_start;
  logic [CW-1:0]                 walk_raddr;
  logic [mlgs_pkg::LIVE_W-1:0]   live;
  mlgs_pkg::walk_stat_t          walk_stat;

  logic                          wr_cell_ok;
  logic                          wr_row_ok;
  logic                          wr_nb_ok;
  logic                          rd_ok;

  assign cfg.ready   = 1'b1;
  assign item.ready  = (state == S_IDLE) && (!res_valid || result.ready);
  assign in_xfer     = item.valid && item.ready;

  assign result.valid       = res_valid;
  assign result.cell_alive  = res_alive;
  assign result.any_changed = res_any;
  assign result.status      = res_status;

  assign wr_cell_ok = (32'(item.index) < MAX_CELLS) && (item.value <= 14'd1);
  assign wr_row_ok  = (32'(item.index) <= MAX_CELLS) && (32'(item.value) <= MAX_EDGES);
  assign wr_nb_ok   = (32'(item.index) < MAX_EDGES) && (32'(item.value) < MAX_CELLS);
  assign rd_ok      = 32'(item.index) < MAX_CELLS;

  assign n_lim     = (32'(cell_count) > MAX_CELLS) ? CNW'(MAX_CELLS) : CNW'(cell_count);
  assign in_use    = 32'(c) < 32'(n_lim);
  assign last_cell = c == CW'(MAX_CELLS-1);
  assign cur_rdata = active_bank ? b_rdata : a_rdata;
  assign me_bit    = (state == S_HI) ? cur_rdata : me_r;

  assign nx = me_bit ? ((live == mlgs_pkg::SURVIVE_LOW) || (live == mlgs_pkg::SURVIVE_HIGH))
                     : (live == mlgs_pkg::BIRTH_COUNT);
  assign new_bit = in_use ? nx : me_bit;
  assign flip    = in_use && (nx != me_bit);
  assign commit  = ((state == S_HI) && !in_use) || ((state == S_EDGE) && walk_stat.done);

  assign hi_clamped = (32'(rs_rdata) > MAX_EDGES) ? OW'(MAX_EDGES) : rs_rdata;

  // row end of cell c is row start of c+1; the first start is fetched per generation
  assign rs_raddr = (state == S_GEN) ? '0 : RSW'(c) + RSW'(1);

  always_comb begin
    c_raddr = c;
    if (state == S_EDGE) begin
      c_raddr = walk_raddr;
    end else if (state == S_IDLE) begin
      c_raddr = CW'(item.index);
    end
  end

  always_comb begin
    state_next      = state;
    res_load        = 1'b0;
    res_alive_next  = 1'b0;
    res_any_next    = 1'b0;
    res_status_next = mlgs_pkg::STATUS_DONE;
    a_we            = 1'b0;
    b_we            = 1'b0;
    c_waddr         = c;
    c_wdata         = 1'b0;
    rs_we           = 1'b0;
    nl_we           = 1'b0;
    walk_start      = 1'b0;

    case (state)
      S_CLEAR: begin
        a_we    = 1'b1;
        b_we    = 1'b1;
        c_waddr = clr;
        if (clr == CW'(MAX_CELLS-1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (mlgs_pkg::opcode_t'(item.opcode))
            mlgs_pkg::OP_WRITE_CELL: begin
              res_load = 1'b1;
              if (wr_cell_ok) begin
                a_we    = !active_bank;
                b_we    = active_bank;
                c_waddr = CW'(item.index);
                c_wdata = item.value[0];
              end else begin
                res_status_next = mlgs_pkg::STATUS_RANGE;
              end
            end
            mlgs_pkg::OP_WRITE_ROW: begin
              res_load = 1'b1;
              if (wr_row_ok) begin
                rs_we = 1'b1;
              end else begin
                res_status_next = mlgs_pkg::STATUS_RANGE;
              end
            end
            mlgs_pkg::OP_WRITE_NEIGHBOR: begin
              res_load = 1'b1;
              if (wr_nb_ok) begin
                nl_we = 1'b1;
              end else begin
                res_status_next = mlgs_pkg::STATUS_RANGE;
              end
            end
            mlgs_pkg::OP_RUN: begin
              if (item.generations == '0) begin
                res_load = 1'b1;
              end else begin
                state_next = S_GEN;
              end
            end
            mlgs_pkg::OP_READ_CELL: begin
              if (rd_ok) begin
                state_next = S_READ;
              end else begin
                res_load        = 1'b1;
                res_status_next = mlgs_pkg::STATUS_RANGE;
              end
            end
            default: begin
              res_load        = 1'b1;
              res_status_next = mlgs_pkg::STATUS_RANGE;
            end
          endcase
        end
      end
      S_READ: begin
        res_load       = 1'b1;
        res_alive_next = cur_rdata;
        state_next     = S_IDLE;
      end
      S_GEN: begin
        state_next = S_CELL;
      end
      S_CELL: begin
        state_next = S_HI;
      end
      S_HI: begin
        if (in_use) begin
          walk_start = 1'b1;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // write the next-generation bit into the other bank
    if (commit) begin
      a_we    = active_bank;
      b_we    = !active_bank;
      c_waddr = c;
      c_wdata = new_bit;
      if (!last_cell) begin
        state_next = S_CELL;
      end else if (gens_left == mlgs_pkg::GENS_W'(1)) begin
        res_load     = 1'b1;
        res_any_next = gen_changed || flip;
        state_next   = S_IDLE;
      end else begin
        state_next = S_GEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      active_bank <= 1'b0;
      cell_count  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + CW'(1);
      end
      if (cfg.valid && cfg.ready) begin
        cell_count <= cfg.cell_count;
      end
      if (commit && last_cell) begin
        active_bank <= !active_bank;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_alive  <= res_alive_next;
      res_any    <= res_any_next;
      res_status <= res_status_next;
    end
    if (in_xfer) begin
      gens_left <= item.generations;
    end else if (commit && last_cell) begin
      gens_left <= gens_left - mlgs_pkg::GENS_W'(1);
    end
    if (state == S_GEN) begin
      c           <= '0;
      gen_changed <= 1'b0;
    end else if (commit) begin
      c           <= c + CW'(1);
      gen_changed <= gen_changed || flip;
    end
    if ((state == S_CELL) && (c == '0)) begin
      lo <= rs_rdata;
    end else if (commit) begin
      lo <= hi_raw;
    end
    if (state == S_HI) begin
      hi_raw <= rs_rdata;
      me_r   <= cur_rdata;
    end
  end

  mlgs_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_cells_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (a_rdata)
  );

  mlgs_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_cells_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (b_rdata)
  );

  mlgs_ram #(.WIDTH(OW), .DEPTH(MAX_CELLS+1)) u_row_starts (
    .clk   (clk),
    .we    (rs_we),
    .waddr (RSW'(item.index)),
    .wdata (OW'(item.value)),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  mlgs_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_neighbor_list (
    .clk   (clk),
    .we    (nl_we),
    .waddr (EW'(item.index)),
    .wdata (CW'(item.value)),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  mlgs_edge_walk #(.MAX_CELLS(MAX_CELLS), .MAX_EDGES(MAX_EDGES)) u_edge_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .lo         (lo),
    .hi         (hi_clamped),
    .nl_raddr   (nl_raddr),
    .nl_rdata   (nl_rdata),
    .cell_raddr (walk_raddr),
    .cell_rdata (cur_rdata),
    .live       (live),
    .stat       (walk_stat)
  );

`ifndef SYNTHESIS
  // both banks written together only by the clearing pass
  a_dual_write_clear: assert property (@(posedge clk) disable iff (rst)
    (a_we && b_we) |-> (state == S_CLEAR))
    else $error("both cell banks written outside the clearing pass");

  a_no_transfer_walk: assert property (@(posedge clk) disable iff (rst)
    walk_stat.busy |-> !(item.valid && item.ready))
    else $error("item transfer while a row walk is in progress");

  a_walk_in_edge: assert property (@(posedge clk) disable iff (rst)
    walk_stat.busy |-> (state == S_EDGE))
    else $error("row walk active outside the edge state");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (active_bank != $past(active_bank)))
      |-> $past((state == S_EDGE) || (state == S_HI)))
    else $error("bank swap outside a generation end");
`endif

endmodule

// ----- rtl/core/mlgs_ram.sv -----
// ----------------------------------------------------------------------------
// mlgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mlgs_edge_walk.sv -----
// ----------------------------------------------------------------------------
// mlgs_edge_walk
// Walks one adjacency row: neighbour list read, then cell read, one edge a
// cycle, counting live neighbours with saturation.
// ----------------------------------------------------------------------------
module mlgs_edge_walk #(
  parameter int MAX_CELLS = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [$clog2(MAX_EDGES+1)-1:0]   lo,
  input  logic [$clog2(MAX_EDGES+1)-1:0]   hi,
  output logic [$clog2(MAX_EDGES)-1:0]     nl_raddr,
  input  logic [$clog2(MAX_CELLS)-1:0]     nl_rdata,
  output logic [$clog2(MAX_CELLS)-1:0]     cell_raddr,
  input  logic                             cell_rdata,
  output logic [mlgs_pkg::LIVE_W-1:0]      live,
  output mlgs_pkg::walk_stat_t             stat
);

  localparam int OW = $clog2(MAX_EDGES+1);
  localparam int EW = $clog2(MAX_EDGES);

  logic          active;
  logic          p1;
  logic          p2;
  logic [OW-1:0] e;
  logic [OW-1:0] hi_r;
  logic          issue;
  logic          nb_ok;

  assign issue      = active && (e < hi_r);
  assign nb_ok      = 32'(nl_rdata) < MAX_CELLS;
  assign nl_raddr   = e[EW-1:0];
  assign cell_raddr = nl_rdata;

  assign stat.busy = active;
  assign stat.done = active && !issue && !p1 && !p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      p1     <= 1'b0;
      p2     <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      p1     <= 1'b0;
      p2     <= 1'b0;
    end else begin
      p1 <= issue;
      p2 <= p1 && nb_ok;
      if (stat.done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e    <= lo;
      hi_r <= hi;
      live <= '0;
    end else begin
      if (issue) begin
        e <= e + OW'(1);
      end
      // count a live neighbour once its cell bit is back
      if (p2 && cell_rdata && (live != mlgs_pkg::LIVE_SAT)) begin
        live <= live + mlgs_pkg::LIVE_W'(1);
      end
    end
  end

endmodule
